>>> rtl/core/lbs_pkg.sv
// lbs_pkg: shared types, codes and timing constants for the link bring-up sequencer
// used by link_bringup_sequencer_unit and its port checker; no dependencies
package lbs_pkg;

  parameter int unsigned RING_DEPTH_DEF = 8;

  // step timeouts in milliseconds
  parameter int unsigned T_RESET_LOW = 50;
  parameter int unsigned T_BOOT      = 1500;
  parameter int unsigned T_STATION   = 2000;
  parameter int unsigned T_WIFI      = 15000;
  parameter int unsigned T_USERCFG   = 3000;
  parameter int unsigned T_CONNECT   = 10000;
  parameter int unsigned T_SUBSCRIBE = 5000;

  // register reset values
  parameter logic [2:0]  RST_CONNECT_RETRY = 3'd3;
  parameter logic [2:0]  RST_PUBLISH_RETRY = 3'd2;
  parameter logic [15:0] RST_BACKOFF_MIN   = 16'd2000;
  parameter logic [15:0] RST_BACKOFF_MAX   = 16'd30000;
  parameter logic [15:0] RST_TELEM_PERIOD  = 16'd5000;
  parameter logic [15:0] RST_PUB_TIMEOUT   = 16'd5000;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_OK      = 3'd1,
    CMD_ERROR   = 3'd2,
    CMD_DROPPED = 3'd3,
    CMD_REPLY   = 3'd4
  } cmd_t;

  typedef enum logic [3:0] {
    PH_RESET     = 4'd0,
    PH_STATION   = 4'd1,
    PH_WIFI      = 4'd2,
    PH_USERCFG   = 4'd3,
    PH_WILL      = 4'd4,
    PH_CONNECT   = 4'd5,
    PH_SUBSCRIBE = 4'd6,
    PH_ONLINE    = 4'd7,
    PH_BACKOFF   = 4'd8
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE      = 4'd0,
    ACT_HOLD_RST  = 4'd1,
    ACT_REL_RST   = 4'd2,
    ACT_STATION   = 4'd3,
    ACT_WIFI      = 4'd4,
    ACT_USERCFG   = 4'd5,
    ACT_WILL      = 4'd6,
    ACT_CONNECT   = 4'd7,
    ACT_SUBSCRIBE = 4'd8,
    ACT_STATUS    = 4'd9,
    ACT_REPLY     = 4'd10,
    ACT_TELEMETRY = 4'd11,
    ACT_RESEND    = 4'd12
  } action_t;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_STATUS    = 2'd1,
    KIND_REPLY     = 2'd2,
    KIND_TELEMETRY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CFG_CONNECT_RETRY = 3'd0,
    CFG_PUBLISH_RETRY = 3'd1,
    CFG_BACKOFF_MIN   = 3'd2,
    CFG_BACKOFF_MAX   = 3'd3,
    CFG_TELEM_PERIOD  = 3'd4,
    CFG_PUB_TIMEOUT   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]         command;
    logic [31:0]        now_ms;
    logic [31:0]        reply_id;
    logic [2:0]         reply_code;
    logic signed [31:0] reply_actual;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         action;
    logic [3:0]         phase;
    logic [31:0]        out_reply_id;
    logic [2:0]         out_reply_code;
    logic signed [31:0] out_reply_actual;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        id;
    logic [2:0]         code;
    logic signed [31:0] actual;
  } ring_entry_t;

  // wrap-safe deadline test: reached once now is at or past the deadline
  function automatic logic reached(input logic [31:0] now, input logic [31:0] dl);
    logic [31:0] diff;
    diff = now - dl;
    return ~diff[31];
  endfunction

endpackage

>>> rtl/core/link_bringup_sequencer_unit.sv
// link_bringup_sequencer_unit: bring-up phase machine, publish arbiter and reply ring
// depends on lbs_pkg
//
// usage: one request per event on the in_ channel (tick with time, ok line, error
// line, link drop, reply to queue); exactly one result per request on out_, carrying
// the action code, the phase after the event and, for a reply publish or resend,
// the queued reply at the ring tail.
// a result is registered: in the result register, or in the skid register on stall.
// throughput: one request per cycle unless in_stall; all of an event's work is one
// pass of flag and 32-bit add/compare logic between the state and result registers.
// the reply ring is a one-write one-read memory whose tail entry is held in a
// registered read port, so a publish never waits on it. stalls: a result register
// plus a skid register sit on out_; in_stall rises only when both hold results, so
// one request is still taken while a result waits. reset (rst_n low, synchronous):
// phase goes to module reset, flags and ring pointers clear, registers return to
// their defaults; ring contents are not cleared, an empty ring is never read. cfg_
// writes take effect at once; the user makes them while idle, not enforced by the block.
module link_bringup_sequencer_unit #(
  parameter int unsigned RING_DEPTH = lbs_pkg::RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lbs_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output lbs_pkg::out_item_t out_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_wdata
);

  localparam int unsigned RIDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  function automatic logic [RIDX_W-1:0] ring_inc(input logic [RIDX_W-1:0] idx);
    return (idx == RIDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // configuration registers
  logic [2:0]  conn_limit_r, pub_limit_r;
  logic [15:0] backoff_min_r, backoff_max_r, telem_period_r, pub_timeout_r;

  // sequencer state
  lbs_pkg::phase_t phase_r, phase_nxt;
  lbs_pkg::kind_t  send_kind_r, send_kind_nxt;
  logic        cmd_sent_r, cmd_sent_nxt;
  logic [2:0]  conn_left_r, conn_left_nxt;
  logic        saw_ok_r, saw_ok_nxt;
  logic        saw_err_r, saw_err_nxt;
  logic        link_lost_r, link_lost_nxt;
  logic        released_r, released_nxt;
  logic [31:0] deadline_r, deadline_nxt;
  logic [16:0] backoff_r, backoff_nxt;
  logic [31:0] next_tel_r, next_tel_nxt;
  logic        status_want_r, status_want_nxt;
  logic        tel_want_r, tel_want_nxt;
  logic        pub_busy_r, pub_busy_nxt;
  logic [2:0]  pub_left_r, pub_left_nxt;
  logic [RIDX_W-1:0] head_r, head_nxt, tail_r, tail_nxt, tail_rd;

  // reply ring
  lbs_pkg::ring_entry_t ring_mem [RING_DEPTH];
  lbs_pkg::ring_entry_t tail_entry_r, wr_entry;
  logic ring_we;

  // output stage
  logic               out_valid_r, skid_valid_r;
  lbs_pkg::out_item_t out_item_r, skid_item_r, result;
  logic               in_fire, out_free;

  // step scratch
  lbs_pkg::action_t action;
  lbs_pkg::phase_t  enter_ph, step_next;
  lbs_pkg::action_t step_code;
  logic        enter_en;
  logic [31:0] step_timeout;
  logic [31:0] now;
  logic        confirm;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign now       = in_item.now_ms;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_limit_r   <= lbs_pkg::RST_CONNECT_RETRY;
      pub_limit_r    <= lbs_pkg::RST_PUBLISH_RETRY;
      backoff_min_r  <= lbs_pkg::RST_BACKOFF_MIN;
      backoff_max_r  <= lbs_pkg::RST_BACKOFF_MAX;
      telem_period_r <= lbs_pkg::RST_TELEM_PERIOD;
      pub_timeout_r  <= lbs_pkg::RST_PUB_TIMEOUT;
    end else if (cfg_we) begin
      case (lbs_pkg::cfg_idx_t'(cfg_index))
        lbs_pkg::CFG_CONNECT_RETRY: conn_limit_r   <= cfg_wdata[2:0];
        lbs_pkg::CFG_PUBLISH_RETRY: pub_limit_r    <= cfg_wdata[2:0];
        lbs_pkg::CFG_BACKOFF_MIN:   backoff_min_r  <= cfg_wdata;
        lbs_pkg::CFG_BACKOFF_MAX:   backoff_max_r  <= cfg_wdata;
        lbs_pkg::CFG_TELEM_PERIOD:  telem_period_r <= cfg_wdata;
        lbs_pkg::CFG_PUB_TIMEOUT:   pub_timeout_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    cmd_sent_nxt    = cmd_sent_r;
    conn_left_nxt   = conn_left_r;
    saw_ok_nxt      = saw_ok_r;
    saw_err_nxt     = saw_err_r;
    link_lost_nxt   = link_lost_r;
    released_nxt    = released_r;
    deadline_nxt    = deadline_r;
    backoff_nxt     = backoff_r;
    next_tel_nxt    = next_tel_r;
    status_want_nxt = status_want_r;
    tel_want_nxt    = tel_want_r;
    pub_busy_nxt    = pub_busy_r;
    pub_left_nxt    = pub_left_r;
    send_kind_nxt   = send_kind_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    action          = lbs_pkg::ACT_NONE;
    enter_en        = 1'b0;
    enter_ph        = lbs_pkg::PH_RESET;
    step_code       = lbs_pkg::ACT_NONE;
    step_next       = lbs_pkg::PH_RESET;
    step_timeout    = '0;
    confirm         = 1'b0;
    ring_we         = 1'b0;
    wr_entry.id     = in_item.reply_id;
    wr_entry.code   = in_item.reply_code;
    wr_entry.actual = in_item.reply_actual;

    case (lbs_pkg::cmd_t'(in_item.command))
      lbs_pkg::CMD_TICK: begin
        case (phase_r)
          lbs_pkg::PH_RESET: begin
            if (!cmd_sent_r) begin
              released_nxt = 1'b0;
              deadline_nxt = now + 32'(lbs_pkg::T_RESET_LOW);
              cmd_sent_nxt = 1'b1;
              action       = lbs_pkg::ACT_HOLD_RST;
            end else if (!released_r) begin
              if (lbs_pkg::reached(now, deadline_r)) begin
                released_nxt = 1'b1;
                deadline_nxt = now + 32'(lbs_pkg::T_BOOT);
                action       = lbs_pkg::ACT_REL_RST;
              end
            end else if (lbs_pkg::reached(now, deadline_r)) begin
              enter_en = 1'b1;
              enter_ph = lbs_pkg::PH_STATION;
            end
          end
          lbs_pkg::PH_STATION, lbs_pkg::PH_WIFI, lbs_pkg::PH_USERCFG,
          lbs_pkg::PH_CONNECT, lbs_pkg::PH_SUBSCRIBE: begin
            unique case (phase_r)
              lbs_pkg::PH_STATION: begin
                step_code = lbs_pkg::ACT_STATION;
                step_next = lbs_pkg::PH_WIFI;
                step_timeout = 32'(lbs_pkg::T_STATION);
              end
              lbs_pkg::PH_WIFI: begin
                step_code = lbs_pkg::ACT_WIFI;
                step_next = lbs_pkg::PH_USERCFG;
                step_timeout = 32'(lbs_pkg::T_WIFI);
              end
              lbs_pkg::PH_USERCFG: begin
                step_code = lbs_pkg::ACT_USERCFG;
                step_next = lbs_pkg::PH_WILL;
                step_timeout = 32'(lbs_pkg::T_USERCFG);
              end
              lbs_pkg::PH_CONNECT: begin
                step_code = lbs_pkg::ACT_CONNECT;
                step_next = lbs_pkg::PH_SUBSCRIBE;
                step_timeout = 32'(lbs_pkg::T_CONNECT);
              end
              default: begin
                step_code = lbs_pkg::ACT_SUBSCRIBE;
                step_next = lbs_pkg::PH_ONLINE;
                step_timeout = 32'(lbs_pkg::T_SUBSCRIBE);
              end
            endcase
            if (!cmd_sent_r) begin
              cmd_sent_nxt = 1'b1;
              saw_ok_nxt   = 1'b0;
              saw_err_nxt  = 1'b0;
              deadline_nxt = now + step_timeout;
              action       = step_code;
            end else if (saw_ok_r) begin
              enter_en = 1'b1;
              enter_ph = step_next;
            end else if (saw_err_r || lbs_pkg::reached(now, deadline_r)) begin
              if (conn_left_r != 3'd0) begin
                conn_left_nxt = conn_left_r - 3'd1;
                cmd_sent_nxt  = 1'b0;
              end else begin
                enter_en = 1'b1;
                enter_ph = lbs_pkg::PH_BACKOFF;
              end
            end
          end
          lbs_pkg::PH_WILL: begin
            // best effort: any answer or a timeout moves on
            if (!cmd_sent_r) begin
              cmd_sent_nxt = 1'b1;
              saw_ok_nxt   = 1'b0;
              saw_err_nxt  = 1'b0;
              deadline_nxt = now + 32'(lbs_pkg::T_USERCFG);
              action       = lbs_pkg::ACT_WILL;
            end else if (saw_ok_r || saw_err_r || lbs_pkg::reached(now, deadline_r)) begin
              enter_en = 1'b1;
              enter_ph = lbs_pkg::PH_CONNECT;
            end
          end
          lbs_pkg::PH_ONLINE: begin
            if (link_lost_r) begin
              enter_en = 1'b1;
              enter_ph = lbs_pkg::PH_BACKOFF;
            end else begin
              if (lbs_pkg::reached(now, next_tel_r)) begin
                tel_want_nxt = 1'b1;
                next_tel_nxt = now + 32'(telem_period_r);
              end
              if (pub_busy_r) begin
                if (saw_ok_r) begin
                  confirm = 1'b1;
                end else if (saw_err_r || lbs_pkg::reached(now, deadline_r)) begin
                  if (pub_left_r != 3'd0) begin
                    pub_left_nxt = pub_left_r - 3'd1;
                    saw_ok_nxt   = 1'b0;
                    saw_err_nxt  = 1'b0;
                    deadline_nxt = now + 32'(pub_timeout_r);
                    action       = lbs_pkg::ACT_RESEND;
                  end else begin
                    confirm = 1'b1;
                  end
                end
              end else if (status_want_r || (head_r != tail_r) || tel_want_nxt) begin
                // priority: status, queued reply, telemetry
                priority if (status_want_r) begin
                  send_kind_nxt = lbs_pkg::KIND_STATUS;
                  action        = lbs_pkg::ACT_STATUS;
                end else if (head_r != tail_r) begin
                  send_kind_nxt = lbs_pkg::KIND_REPLY;
                  action        = lbs_pkg::ACT_REPLY;
                end else begin
                  send_kind_nxt = lbs_pkg::KIND_TELEMETRY;
                  action        = lbs_pkg::ACT_TELEMETRY;
                end
                pub_busy_nxt = 1'b1;
                pub_left_nxt = pub_limit_r;
                saw_ok_nxt   = 1'b0;
                saw_err_nxt  = 1'b0;
                deadline_nxt = now + 32'(pub_timeout_r);
              end
              if (confirm) begin
                unique case (send_kind_r)
                  lbs_pkg::KIND_STATUS:    status_want_nxt = 1'b0;
                  lbs_pkg::KIND_REPLY:     tail_nxt = ring_inc(tail_r);
                  lbs_pkg::KIND_TELEMETRY: tel_want_nxt = 1'b0;
                  default: ;
                endcase
                pub_busy_nxt  = 1'b0;
                send_kind_nxt = lbs_pkg::KIND_NONE;
              end
            end
          end
          default: begin
            // backoff wait, and any unused phase code
            if (lbs_pkg::reached(now, deadline_r)) begin
              enter_en = 1'b1;
              enter_ph = lbs_pkg::PH_RESET;
            end
          end
        endcase
      end
      lbs_pkg::CMD_OK:      saw_ok_nxt    = 1'b1;
      lbs_pkg::CMD_ERROR:   saw_err_nxt   = 1'b1;
      lbs_pkg::CMD_DROPPED: link_lost_nxt = 1'b1;
      lbs_pkg::CMD_REPLY: begin
        // full ring drops the new reply
        if (ring_inc(head_r) != tail_r) begin
          ring_we  = 1'b1;
          head_nxt = ring_inc(head_r);
        end
      end
      default: ;
    endcase

    if (enter_en) begin
      phase_nxt     = enter_ph;
      cmd_sent_nxt  = 1'b0;
      saw_ok_nxt    = 1'b0;
      saw_err_nxt   = 1'b0;
      conn_left_nxt = conn_limit_r;
      if (enter_ph == lbs_pkg::PH_ONLINE) begin
        link_lost_nxt   = 1'b0;
        pub_busy_nxt    = 1'b0;
        send_kind_nxt   = lbs_pkg::KIND_NONE;
        status_want_nxt = 1'b1;
        tel_want_nxt    = 1'b1;
        next_tel_nxt    = now + 32'(telem_period_r);
        backoff_nxt     = {1'b0, backoff_min_r};
      end else if (enter_ph == lbs_pkg::PH_BACKOFF) begin
        deadline_nxt = now + 32'(backoff_r);
        backoff_nxt  = (backoff_r < {1'b0, backoff_max_r}) ? {backoff_r[15:0], 1'b0}
                                                          : {1'b0, backoff_max_r};
      end
    end

    result.action = action;
    result.phase  = phase_nxt;
    if (action == lbs_pkg::ACT_REPLY ||
        (action == lbs_pkg::ACT_RESEND && send_kind_r == lbs_pkg::KIND_REPLY)) begin
      result.out_reply_id     = tail_entry_r.id;
      result.out_reply_code   = tail_entry_r.code;
      result.out_reply_actual = tail_entry_r.actual;
    end else begin
      result.out_reply_id     = '0;
      result.out_reply_code   = '0;
      result.out_reply_actual = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= lbs_pkg::PH_RESET;
      cmd_sent_r    <= 1'b0;
      conn_left_r   <= lbs_pkg::RST_CONNECT_RETRY;
      saw_ok_r      <= 1'b0;
      saw_err_r     <= 1'b0;
      link_lost_r   <= 1'b0;
      released_r    <= 1'b0;
      deadline_r    <= '0;
      backoff_r     <= {1'b0, lbs_pkg::RST_BACKOFF_MIN};
      next_tel_r    <= '0;
      status_want_r <= 1'b0;
      tel_want_r    <= 1'b0;
      pub_busy_r    <= 1'b0;
      pub_left_r    <= '0;
      send_kind_r   <= lbs_pkg::KIND_NONE;
      head_r        <= '0;
      tail_r        <= '0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      cmd_sent_r    <= cmd_sent_nxt;
      conn_left_r   <= conn_left_nxt;
      saw_ok_r      <= saw_ok_nxt;
      saw_err_r     <= saw_err_nxt;
      link_lost_r   <= link_lost_nxt;
      released_r    <= released_nxt;
      deadline_r    <= deadline_nxt;
      backoff_r     <= backoff_nxt;
      next_tel_r    <= next_tel_nxt;
      status_want_r <= status_want_nxt;
      tel_want_r    <= tel_want_nxt;
      pub_busy_r    <= pub_busy_nxt;
      pub_left_r    <= pub_left_nxt;
      send_kind_r   <= send_kind_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
    end
  end

  // ring memory: write at head, registered read follows the tail with write bypass
  assign tail_rd = !rst_n ? '0 : (in_fire ? tail_nxt : tail_r);

  always_ff @(posedge clk) begin
    if (in_fire && ring_we) begin
      ring_mem[head_r] <= wr_entry;
    end
    if (in_fire && ring_we && head_r == tail_rd) begin
      tail_entry_r <= wr_entry;
    end else begin
      tail_entry_r <= ring_mem[tail_rd];
    end
  end

  // result register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_item_r <= skid_valid_r ? skid_item_r : result;
    end
    if (!out_free && in_fire) begin
      skid_item_r <= result;
    end
  end

endmodule

>>> rtl/core/lbs_port_checker.sv
// lbs_port_checker: port-level checks on the link bring-up sequencer results
// depends on lbs_pkg; bound to link_bringup_sequencer_unit below
module lbs_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input lbs_pkg::out_item_t out_item
);

  // a held result must not change under stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // publishes only happen while online
  a_pub_online: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.action == lbs_pkg::ACT_STATUS ||
                  out_item.action == lbs_pkg::ACT_REPLY ||
                  out_item.action == lbs_pkg::ACT_TELEMETRY ||
                  out_item.action == lbs_pkg::ACT_RESEND)
      |-> out_item.phase == lbs_pkg::PH_ONLINE)
    else $error("publish action outside online phase");

  // reply fields are zero unless the action is a reply publish or a resend
  a_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.action != lbs_pkg::ACT_REPLY &&
    out_item.action != lbs_pkg::ACT_RESEND
      |-> out_item.out_reply_id == '0 && out_item.out_reply_code == '0 &&
          out_item.out_reply_actual == '0)
    else $error("reply fields set without a reply publish");

  // input request taken and no stall means a result follows next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (!out_valid || !out_stall) |=> out_valid)
    else $error("accepted request produced no result");

endmodule

bind link_bringup_sequencer_unit lbs_port_checker u_lbs_port_checker (.*);
